// ===== sv/lpr_pkg.sv =====
// Shared types and constants of the longest-prefix route lookup.
`timescale 1ns / 1ps
package lpr_pkg;

  localparam int LPR_ROUTES  = 1024;
  localparam int LPR_ADDR_W  = 32;
  localparam int LPR_PORT_W  = 2;
  localparam int LPR_LEN_W   = 6;

  // Highest accepted output interface is LPR_PORTS - 1.
  localparam int LPR_PORTS   = 4;
  localparam int LPR_PCMP_W  = 7;

  localparam int LPR_IN_DATA_W  = 136;
  localparam int LPR_OUT_DATA_W = 40;
  localparam int LPR_IN_USER_W  = 1;
  localparam int LPR_OUT_USER_W = 2;

  localparam logic LPR_FUNC_INSERT = 1'b0;
  localparam logic LPR_FUNC_LOOKUP = 1'b1;

  localparam int LPR_OUT_FOUND_BIT = 0;
  localparam int LPR_OUT_OK_BIT    = 1;

  typedef struct packed {
    logic [LPR_PORT_W-1:0] port;
    logic [LPR_ADDR_W-1:0] gateway;
    logic [LPR_ADDR_W-1:0] mask;
    logic [LPR_ADDR_W-1:0] prefix;
  } lpr_entry_t;

  typedef struct packed {
    logic                  hit;
    logic [LPR_LEN_W-1:0]  len;
    logic [LPR_PORT_W-1:0] port;
    logic [LPR_ADDR_W-1:0] gateway;
  } lpr_best_t;

endpackage

// ===== sv/lpr_table.sv =====
// Route table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module lpr_table #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES,
  localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  lpr_pkg::lpr_entry_t wr_entry,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output lpr_pkg::lpr_entry_t rd_entry,
  output logic               rd_valid
);
  import lpr_pkg::*;

  lpr_entry_t mem [ROUTES];
  lpr_entry_t rd_entry_r;
  logic       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

// ===== sv/lpr_match.sv =====
// Shared match unit: masked compare and mask weight, then best-route update.
`timescale 1ns / 1ps
module lpr_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          rd_valid,
  input  lpr_pkg::lpr_entry_t           rd_entry,
  input  logic [lpr_pkg::LPR_ADDR_W-1:0] dest_addr,
  output lpr_pkg::lpr_best_t            best
);
  import lpr_pkg::*;

  logic                  hit_now;
  logic [LPR_LEN_W-1:0]  len_now;

  logic                  m_valid_r;
  logic                  m_hit_r;
  logic [LPR_LEN_W-1:0]  m_len_r;
  logic [LPR_PORT_W-1:0] m_port_r;
  logic [LPR_ADDR_W-1:0] m_nh_r;

  lpr_best_t best_r;
  logic      take;

  assign hit_now = ((rd_entry.prefix ^ dest_addr) & rd_entry.mask) == '0;
  assign len_now = LPR_LEN_W'($countones(rd_entry.mask));

  // Stage one: compare and weigh the entry just read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= rd_valid && !clear;
    end
    m_hit_r  <= hit_now;
    m_len_r  <= len_now;
    m_port_r <= rd_entry.port;
    m_nh_r   <= rd_entry.gateway;
  end

  // Strictly longer wins, so the earliest of equal weight is kept.
  assign take = m_valid_r && m_hit_r && (!best_r.hit || (m_len_r > best_r.len));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      best_r <= '0;
    end else if (take) begin
      best_r.hit     <= 1'b1;
      best_r.len     <= m_len_r;
      best_r.port    <= m_port_r;
      best_r.gateway <= m_nh_r;
    end
  end

  assign best = best_r;

endmodule

// ===== sv/longest_prefix_route_lookup.sv =====
// Top level of the longest-prefix route lookup with its scan sequencer.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_*: one item per handshake. in_tuser is the function
//   (0 inserts a route, 1 looks up dest_addr). in_tdata carries the route
//   fields and the destination address.
//   Result channel out_*: exactly one item per input item, in order.
//   Insert: the route is written at the accept edge when the table has room
//   and the port is valid; the result passes ST_DONE into the output register.
//   Lookup: the sequencer reads one stored route per cycle from the table
//   memory and feeds the shared match unit; after the last read the result
//   passes the read data register, the match stage and ST_DONE into the
//   output register. The memory read port, one entry a cycle, sets the scan
//   length. The next item can be taken in the same cycle that the result
//   appears.
//   in_tready is high only while the sequencer is idle; one item is worked
//   at a time.
//   Stall: a finished result waits in the output register while out_tready is
//   low; the next item is accepted but its result holds until the register
//   drains.
//   Reset (rst_n low, synchronous): empty the table (route count to zero),
//   drop any pending result and return to idle. Table contents need no clear.
module longest_prefix_route_lookup #(
  parameter int ROUTES = lpr_pkg::LPR_ROUTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] route_prefix, [63:32] route_mask, [95:64] route gateway (next hop),
  // [97:96] route_port, [129:98] dest_addr, [135:130] zero
  input  logic [lpr_pkg::LPR_IN_DATA_W-1:0]  in_tdata,
  // [0] func
  input  logic [lpr_pkg::LPR_IN_USER_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] result gateway (next hop), [33:32] out_port, [39:34] match_length
  output logic [lpr_pkg::LPR_OUT_DATA_W-1:0] out_tdata,
  // [0] found, [1] insert_ok
  output logic [lpr_pkg::LPR_OUT_USER_W-1:0] out_tuser
);
  import lpr_pkg::*;

  localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
  localparam int CNT_W = $clog2(ROUTES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

  state_t state_r, state_nxt;

  // Input field unpacking.
  logic                  in_func;
  logic [LPR_ADDR_W-1:0] in_route_prefix;
  logic [LPR_ADDR_W-1:0] in_route_mask;
  logic [LPR_ADDR_W-1:0] in_route_gateway;
  logic [LPR_PORT_W-1:0] in_route_port;
  logic [LPR_ADDR_W-1:0] in_dest_addr;

  assign in_func          = in_tuser[0];
  assign in_route_prefix  = in_tdata[31:0];
  assign in_route_mask    = in_tdata[63:32];
  assign in_route_gateway = in_tdata[95:64];
  assign in_route_port    = in_tdata[97:96];
  assign in_dest_addr     = in_tdata[129:98];

  logic                      in_acc;
  logic                      room;
  logic                      ins_ok;
  logic                      last_issue;
  logic                      out_free;

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      drain_r, drain_nxt;
  logic                      lookup_r, lookup_nxt;
  logic                      ok_r, ok_nxt;
  logic [LPR_ADDR_W-1:0]     addr_r, addr_nxt;

  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [LPR_OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [LPR_OUT_USER_W-1:0] out_tuser_r, out_tuser_nxt;

  lpr_entry_t wr_entry;
  lpr_entry_t rd_entry;
  logic       rd_en;
  logic       rd_valid;
  lpr_best_t  best;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign room       = (count_r < CNT_W'(ROUTES));
  assign ins_ok     = room && ({{(LPR_PCMP_W-LPR_PORT_W){1'b0}}, in_route_port}
                               < LPR_PCMP_W'(LPR_PORTS));
  assign last_issue = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign out_free   = !out_tvalid_r || out_tready;
  assign rd_en      = (state_r == ST_SCAN);

  assign wr_entry.prefix  = in_route_prefix;
  assign wr_entry.mask    = in_route_mask;
  assign wr_entry.gateway = in_route_gateway;
  assign wr_entry.port    = in_route_port;

  lpr_table #(
    .ROUTES (ROUTES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc && (in_func == LPR_FUNC_INSERT) && ins_ok),
    .wr_addr  (count_r[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (idx_r),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  lpr_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (in_acc),
    .rd_valid  (rd_valid),
    .rd_entry  (rd_entry),
    .dest_addr (addr_r),
    .best      (best)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    drain_nxt      = drain_r;
    lookup_nxt     = lookup_r;
    ok_nxt         = ok_r;
    addr_nxt       = addr_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    // Retire the waiting result once the receiver takes it.
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt   = '0;
          drain_nxt = 1'b0;
          addr_nxt  = in_dest_addr;
          if (in_func == LPR_FUNC_INSERT) begin
            lookup_nxt = 1'b0;
            ok_nxt     = ins_ok;
            if (ins_ok) begin
              count_nxt = count_r + CNT_W'(1);
            end
            state_nxt = ST_DONE;
          end else begin
            lookup_nxt = 1'b1;
            ok_nxt     = 1'b0;
            // An empty table finds nothing; skip the scan.
            state_nxt  = (count_r == '0) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // Wait out the read data register, then the match stage.
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          if (lookup_r) begin
            out_tdata_nxt = {best.len, best.port, best.gateway};
          end else begin
            out_tdata_nxt = '0;
          end
          out_tuser_nxt                    = '0;
          out_tuser_nxt[LPR_OUT_FOUND_BIT] = lookup_r && best.hit;
          out_tuser_nxt[LPR_OUT_OK_BIT]    = ok_r;
          state_nxt                        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      drain_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      drain_r      <= drain_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r       <= idx_nxt;
    lookup_r    <= lookup_nxt;
    ok_r        <= ok_nxt;
    addr_r      <= addr_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  // The route count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ROUTES))
    else $error("route count beyond table depth");

  // An insert into a full table leaves the count unchanged.
  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == LPR_FUNC_INSERT) && !room) |=> $stable(count_r))
    else $error("insert taken into a full table");

  // A result is never both a hit and a stored insert.
  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[LPR_OUT_FOUND_BIT] && out_tuser[LPR_OUT_OK_BIT]))
    else $error("result marked both found and inserted");

  // Without a hit the route fields of a result are zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[LPR_OUT_FOUND_BIT]) |-> (out_tdata == '0))
    else $error("route fields set on a miss");
`endif

endmodule

// ===== verif/longest_prefix_route_lookup_tb.sv =====
// Self-checking testbench for the longest-prefix route lookup.
`timescale 1ns / 1ps
module longest_prefix_route_lookup_tb;
  import lpr_pkg::*;

  // One input item as the sender sees it; fields that the function ignores still carry data.
  typedef struct {
    logic                  func;
    logic [LPR_ADDR_W-1:0] prefix;
    logic [LPR_ADDR_W-1:0] mask;
    logic [LPR_ADDR_W-1:0] gateway;
    logic [LPR_PORT_W-1:0] port;
    logic [LPR_ADDR_W-1:0] dest;
  } route_item_t;

  // One result item, unpacked from out_tdata and out_tuser.
  typedef struct {
    logic                  found;
    logic [LPR_ADDR_W-1:0] gateway;
    logic [LPR_PORT_W-1:0] port;
    logic [LPR_LEN_W-1:0]  len;
    logic                  insert_ok;
  } route_result_t;

  // Shadow route table plus the queue of results the block still owes.
  class route_lookup_tracker;
    logic [LPR_ADDR_W-1:0] prefix_tab[$];
    logic [LPR_ADDR_W-1:0] mask_tab[$];
    logic [LPR_ADDR_W-1:0] hop_tab[$];
    logic [LPR_PORT_W-1:0] port_tab[$];
    route_result_t         expected_results[$];
    int                    errors;
    int                    results_seen;

    function new();
      errors = 0;
      results_seen = 0;
    endfunction

    // Scan in insertion order; only a strictly longer mask displaces the current best.
    function route_result_t best_route_for(logic [LPR_ADDR_W-1:0] addr);
      route_result_t r;
      int            ones;
      r = '{default: '0};
      foreach (prefix_tab[i]) begin
        if ((mask_tab[i] & prefix_tab[i]) == (mask_tab[i] & addr)) begin
          ones = $countones(mask_tab[i]);
          if (!r.found || ones > r.len) begin
            r.found   = 1'b1;
            r.len     = LPR_LEN_W'(ones);
            r.gateway = hop_tab[i];
            r.port    = port_tab[i];
          end
        end
      end
      return r;
    endfunction

    function void note_item(route_item_t it);
      route_result_t r;
      r = '{default: '0};
      if (it.func == LPR_FUNC_INSERT) begin
        if (prefix_tab.size() < LPR_ROUTES && it.port < LPR_PORTS) begin
          prefix_tab.push_back(it.prefix);
          mask_tab.push_back(it.mask);
          hop_tab.push_back(it.gateway);
          port_tab.push_back(it.port);
          r.insert_ok = 1'b1;
        end
      end else begin
        r = best_route_for(it.dest);
      end
      expected_results.push_back(r);
    endfunction

    task report(string what, logic [LPR_ADDR_W-1:0] want, logic [LPR_ADDR_W-1:0] got);
      errors++;
      $display("%0t: result %0d %s: expected %0h, got %0h", $time, results_seen, what,
               want, got);
    endtask

    task check_result(logic [LPR_OUT_DATA_W-1:0] data, logic [LPR_OUT_USER_W-1:0] user);
      route_result_t w;
      results_seen++;
      if (expected_results.size() == 0) begin
        report("arrived with no item pending", '0, data[31:0]);
        return;
      end
      w = expected_results.pop_front();
      if (user[LPR_OUT_FOUND_BIT] !== w.found)
        report("found", LPR_ADDR_W'(w.found), LPR_ADDR_W'(user[LPR_OUT_FOUND_BIT]));
      if (user[LPR_OUT_OK_BIT] !== w.insert_ok)
        report("insert_ok", LPR_ADDR_W'(w.insert_ok), LPR_ADDR_W'(user[LPR_OUT_OK_BIT]));
      if (data[31:0] !== w.gateway)
        report("gateway", w.gateway, data[31:0]);
      if (data[33:32] !== w.port)
        report("port", LPR_ADDR_W'(w.port), LPR_ADDR_W'(data[33:32]));
      if (data[39:34] !== w.len)
        report("match_length", LPR_ADDR_W'(w.len), LPR_ADDR_W'(data[39:34]));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [LPR_IN_DATA_W-1:0]  in_tdata = '0;
  logic [LPR_IN_USER_W-1:0]  in_tuser = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [LPR_OUT_DATA_W-1:0] out_tdata;
  logic [LPR_OUT_USER_W-1:0] out_tuser;

  // Idle odds in percent, changed between phases.
  int send_idle_pct = 32;
  int recv_idle_pct = 48;

  route_lookup_tracker tracker = new();

  longest_prefix_route_lookup DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Contiguous mask with the given number of leading ones.
  function automatic logic [LPR_ADDR_W-1:0] prefix_mask(int ones);
    return (ones == 0) ? '0 : ~32'h0 << (LPR_ADDR_W - ones);
  endfunction

  // Present an item at the falling edge, hold it until the block takes it, then record it.
  task automatic send_item(input route_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    // [135:130] zero fill above dest_addr
    in_tdata  = {6'd0, it.dest, it.port, it.gateway, it.mask, it.prefix};
    in_tuser  = it.func;
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.note_item(it);
  endtask

  task automatic send_insert(input logic [31:0] pfx, input logic [31:0] msk,
                             input logic [31:0] hop, input logic [1:0] port,
                             input logic [31:0] dest);
    send_item('{func: LPR_FUNC_INSERT, prefix: pfx, mask: msk, gateway: hop, port: port,
                dest: dest});
  endtask

  // Route fields of a lookup are don't-care; fill them from the given pattern, the mask with its inverse.
  task automatic send_lookup(input logic [31:0] addr, input logic [31:0] fill);
    send_item('{func: LPR_FUNC_LOOKUP, prefix: fill, mask: ~fill, gateway: fill,
                port: fill[1:0], dest: addr});
  endtask

  // Random item. Inserts favor contiguous masks and sometimes clone a stored
  // prefix and mask so equal-length ties occur; most lookups aim inside a
  // stored route so the scan actually finds something.
  task automatic make_random_item(input int insert_pct, output route_item_t it);
    int                    pick;
    int                    n;
    logic [LPR_ADDR_W-1:0] m;
    n          = tracker.prefix_tab.size();
    it.prefix  = $urandom;
    it.mask    = $urandom;
    it.gateway = $urandom;
    it.port    = LPR_PORT_W'($urandom);
    it.dest    = $urandom;
    if ($urandom_range(99) < insert_pct) begin
      it.func = LPR_FUNC_INSERT;
      pick = $urandom_range(99);
      if (pick < 55) begin
        it.mask = prefix_mask($urandom_range(32));
      end else if (pick < 75) begin
        it.mask = prefix_mask($urandom_range(8));
      end else if (pick >= 85 && n != 0) begin
        pick      = $urandom_range(n - 1);
        it.prefix = tracker.prefix_tab[pick];
        it.mask   = tracker.mask_tab[pick];
      end
    end else begin
      it.func = LPR_FUNC_LOOKUP;
      if (n != 0 && $urandom_range(99) < 75) begin
        pick    = $urandom_range(n - 1);
        m       = tracker.mask_tab[pick];
        it.dest = (tracker.prefix_tab[pick] & m) | (it.dest & ~m);
      end
    end
  endtask

  task automatic send_random(input int count, input int insert_pct);
    route_item_t it;
    repeat (count) begin
      make_random_item(insert_pct, it);
      send_item(it);
    end
  endtask

  // Drop valid and hold off until every owed result has drained.
  task automatic pause_until_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.expected_results.size() != 0) @(negedge clk);
  endtask

  // Result side: check at the rising edge, pick the next ready at the falling edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready)
        tracker.check_result(out_tdata, out_tuser);
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Empty table: every lookup misses, route fields fully set or clear.
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'h0000_0000, 32'h0000_0000);

    // Default route, host routes at both address extremes, nested /8 and /16,
    // a second /16 on the same prefix that must lose the tie, and a scattered mask.
    send_insert(32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
    send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0, 32'h0000_0000);
    send_insert(32'h0A00_0000, 32'hFF00_0000, 32'h0A0A_0A01, 2'd1, $urandom);
    send_insert(32'h0A01_0000, 32'hFFFF_0000, 32'h0A0A_0A02, 2'd2, $urandom);
    send_insert(32'h0A01_0000, 32'hFFFF_0000, 32'h0A0A_0A03, 2'd3, $urandom);
    send_insert(32'h0102_0304, 32'h0F0F_0F0F, 32'h0C0C_0C0C, 2'd1, $urandom);
    send_insert(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 2'd2, $urandom);

    send_lookup(32'hFFFF_FFFF, 32'h0000_0000);
    send_lookup(32'h0000_0000, 32'hFFFF_FFFF);
    send_lookup(32'h0A01_0203, $urandom);
    send_lookup(32'h0A01_FFFF, $urandom);
    send_lookup(32'h0A02_0304, $urandom);
    send_lookup(32'h0B00_0001, $urandom);
    send_lookup(32'hA1B2_C3D4, $urandom);
    send_lookup(32'hC0A8_0101, $urandom);

    // Sender idles less than the receiver, then the reverse, then neither.
    send_random(200, 30);
    pause_until_drained();

    send_idle_pct = 48;
    recv_idle_pct = 32;
    send_random(200, 30);
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(120, 30);

    // Insert-heavy tail so the last scans run over the largest table.
    send_random(60, 40);

    pause_until_drained();
    repeat (LPR_ROUTES + 16) @(posedge clk);

    if (tracker.expected_results.size() != 0)
      tracker.report("results never arrived",
                     LPR_ADDR_W'(tracker.expected_results.size()), '0);
    if (tracker.errors == 0) begin
      $display("longest_prefix_route_lookup regression: pass");
    end else begin
      $display("longest_prefix_route_lookup regression: fail");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #60_000_000;
    $display("longest_prefix_route_lookup regression: fail");
    $finish;
  end

endmodule
